/* hw/rtl/utxbt_pkg.sv */
`default_nettype none

package utxbt_pkg;

    // Fixed widths of the transmit model.
    localparam int WORD_W    = 16;
    localparam int TICKP_W   = 19;
    localparam int COUNT_W   = 32;
    localparam int LINE_W    = 9;
    localparam int DIV_STEPS = TICKP_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [LINE_W-1:0] LINE_LENGTH_RESET = 9'd227;

    // Period register fields.
    localparam logic [WORD_W-1:0] PERIOD_LOW_MASK = 16'h7fff;
    localparam int                NINE_BIT_POS    = 15;

    // Status word bits.
    localparam logic [WORD_W-1:0] STAT_TBE   = 16'h2000;
    localparam logic [WORD_W-1:0] STAT_TSRE  = 16'h1000;
    localparam logic [WORD_W-1:0] STAT_FIXED = 16'h0800;

    // Configuration register indexes.
    localparam logic CFG_LINE_LENGTH = 1'b0;
    localparam logic CFG_CYCLE_EXACT = 1'b1;

    typedef enum logic [1:0] {
        ACT_PERIOD = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_TICK   = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } state_t;

    typedef struct packed {
        action_t             action;
        logic [WORD_W-1:0]   write_data;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_data;
        logic                tbe_irq;
        logic                load_valid;
        logic [WORD_W-1:0]   shift_word;
    } out_t;

endpackage

`default_nettype wire

/* hw/rtl/uart_tx_buffer_timing.sv */
`default_nettype none

// UART transmit holding buffer and shift register timing.
// Requests arrive on the in_valid/in_ready channel; each carries one action:
// a period register write, a data register write, a status read or one
// line-sync tick. Every request produces exactly one result on the
// out_valid/out_ready channel, carrying the status word, the buffer-empty
// interrupt flag and the word loaded into the shift register, if any.
// Data writes, status reads, ticks and period writes that repeat the stored
// value have their result registered at the accepting edge.
// A period write that changes the period starts a restoring divider that
// produces one quotient bit per cycle over 19 divide steps plus hand-off;
// in_ready stays low meanwhile. The line length and cycle-exact mode live
// in an APB port and must only be written while the block is idle.
// Reset clears all state: period zero, ticks ignored, buffer and shifter
// empty, line length 227. When the receiver stalls, the result waits in the
// output register and a new request is taken only in the cycle in which that
// result is taken as well.
module uart_tx_buffer_timing (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire utxbt_pkg::in_t     in_data,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output utxbt_pkg::out_t         out_data,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // Configuration registers.
    logic [utxbt_pkg::LINE_W-1:0]       line_length_reg;
    logic                               cycle_exact_reg;
    logic                               cfg_write;

    // Transmit state.
    utxbt_pkg::state_t                  state_reg, state_next;
    logic [utxbt_pkg::WORD_W-1:0]       period_reg, period_next;
    logic [utxbt_pkg::TICKP_W-1:0]      tp_reg, tp_next;
    logic [utxbt_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [utxbt_pkg::TICKP_W-1:0]      res1_reg, res1_next;
    logic [utxbt_pkg::TICKP_W-1:0]      res2_reg, res2_next;
    logic [utxbt_pkg::WORD_W-1:0]       hold_word_reg, hold_word_next;
    logic                               hold_full_reg, hold_full_next;
    logic                               busy_reg, busy_next;
    logic                               out_valid_reg, out_valid_next;
    utxbt_pkg::out_t                    out_data_reg, out_data_next;

    logic                               in_fire;
    logic [utxbt_pkg::WORD_W-1:0]       wdata;
    logic                               wnz;
    logic                               tp_gt1;

    // Data write path.
    logic                               ld_old;
    logic                               busy_mid;
    logic                               ld_new;

    // Tick path.
    logic [utxbt_pkg::COUNT_W-1:0]      count_inc;
    logic [utxbt_pkg::TICKP_W-1:0]      tp_minus1;
    logic [utxbt_pkg::TICKP_W-1:0]      res1_inc;
    logic [utxbt_pkg::TICKP_W-1:0]      res2_inc;
    logic [utxbt_pkg::TICKP_W-1:0]      res1_new;
    logic [utxbt_pkg::TICKP_W-1:0]      res2_new;
    logic                               tick_hit;
    logic                               ld_tick;

    // Divider hand-off.
    logic [utxbt_pkg::WORD_W-1:0]       period_term;
    logic [utxbt_pkg::TICKP_W-1:0]      term_ext;
    logic [utxbt_pkg::TICKP_W-1:0]      numer;
    logic [utxbt_pkg::LINE_W-1:0]       divisor;
    logic                               div_start;
    logic                               div_done;
    logic [utxbt_pkg::TICKP_W-1:0]      quotient;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= utxbt_pkg::LINE_LENGTH_RESET;
            cycle_exact_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == utxbt_pkg::CFG_LINE_LENGTH)
            begin
                line_length_reg <= pwdata[utxbt_pkg::LINE_W-1:0];
            end
            else
            begin
                cycle_exact_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == utxbt_pkg::CFG_LINE_LENGTH)
        begin
            prdata = {{(32 - utxbt_pkg::LINE_W){1'b0}}, line_length_reg};
        end
        else
        begin
            prdata = {31'b0, cycle_exact_reg};
        end
    end

    // ------------------------------------------------------------------
    // Datapath helpers.
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == utxbt_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign wdata    = in_data.write_data;
    assign wnz      = wdata != '0;
    assign tp_gt1   = tp_reg > utxbt_pkg::TICKP_W'(1);

    // A data write first drains a waiting buffer into an idle shifter, then
    // stores the new word and, if it is nonzero, tries to load it as well.
    assign ld_old   = !busy_reg && hold_full_reg;
    assign busy_mid = ld_old ? tp_gt1 : busy_reg;
    assign ld_new   = wnz && !busy_mid;

    // Residues of the tick count modulo period-1 and modulo period are kept
    // incrementally. A wrap of the 32-bit count lands on zero, which every
    // modulus divides, so both residues restart there.
    assign count_inc = count_reg + 1'b1;
    assign tp_minus1 = tp_reg - 1'b1;
    assign res1_inc  = res1_reg + 1'b1;
    assign res2_inc  = res2_reg + 1'b1;
    assign res1_new  = (count_inc == '0 || res1_inc == tp_minus1) ? '0 : res1_inc;
    assign res2_new  = (count_inc == '0 || res2_inc == tp_reg) ? '0 : res2_inc;
    assign tick_hit  = (tp_reg == utxbt_pkg::TICKP_W'(1)) || (res1_new == '0)
                       || ((res2_new == '0) && !cycle_exact_reg);
    assign ld_tick   = tick_hit && busy_reg && hold_full_reg;

    // Numerator (low15 + 1) * (9 + ninebit) built from shifts and adds.
    assign period_term = (wdata & utxbt_pkg::PERIOD_LOW_MASK) + 1'b1;
    assign term_ext    = {{(utxbt_pkg::TICKP_W - utxbt_pkg::WORD_W){1'b0}}, period_term};
    assign numer       = (term_ext << 3) + term_ext
                         + (wdata[utxbt_pkg::NINE_BIT_POS] ? term_ext : '0);
    assign divisor     = (line_length_reg == '0) ? utxbt_pkg::LINE_W'(1) : line_length_reg;

    utxbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (numer),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // Sequencer and request handling.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        period_next    = period_reg;
        tp_next        = tp_reg;
        count_next     = count_reg;
        res1_next      = res1_reg;
        res2_next      = res2_reg;
        hold_word_next = hold_word_reg;
        hold_full_next = hold_full_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        case (state_reg)
            utxbt_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_data_next = '0;
                    case (in_data.action)
                        utxbt_pkg::ACT_PERIOD:
                        begin
                            if (wdata != period_reg)
                            begin
                                period_next = wdata;
                                count_next  = '0;
                                res1_next   = '0;
                                res2_next   = '0;
                                div_start   = 1'b1;
                                state_next  = utxbt_pkg::ST_DIV;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        utxbt_pkg::ACT_DATA:
                        begin
                            hold_word_next = wdata;
                            hold_full_next = wnz ? !ld_new : (hold_full_reg && !ld_old);
                            busy_next      = ld_new ? tp_gt1 : busy_mid;
                            out_data_next.tbe_irq    = ld_old || ld_new;
                            out_data_next.load_valid = ld_old || ld_new;
                            if (ld_new)
                            begin
                                out_data_next.shift_word = wdata;
                            end
                            else if (ld_old)
                            begin
                                out_data_next.shift_word = hold_word_reg;
                            end
                            out_valid_next = 1'b1;
                        end
                        utxbt_pkg::ACT_STATUS:
                        begin
                            out_data_next.read_data = utxbt_pkg::STAT_FIXED
                                | (hold_full_reg ? '0 : utxbt_pkg::STAT_TBE)
                                | (busy_reg ? '0 : utxbt_pkg::STAT_TSRE);
                            out_valid_next = 1'b1;
                        end
                        utxbt_pkg::ACT_TICK:
                        begin
                            if (tp_reg != '0)
                            begin
                                count_next = count_inc;
                                res1_next  = res1_new;
                                res2_next  = res2_new;
                                if (tick_hit && busy_reg)
                                begin
                                    busy_next = ld_tick ? tp_gt1 : 1'b0;
                                    if (ld_tick)
                                    begin
                                        hold_full_next           = 1'b0;
                                        out_data_next.tbe_irq    = 1'b1;
                                        out_data_next.load_valid = 1'b1;
                                        out_data_next.shift_word = hold_word_reg;
                                    end
                                end
                            end
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            utxbt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    tp_next        = (quotient == '0) ? utxbt_pkg::TICKP_W'(1) : quotient;
                    out_data_next  = '0;
                    out_valid_next = 1'b1;
                    state_next     = utxbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = utxbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= utxbt_pkg::ST_IDLE;
            period_reg    <= '0;
            tp_reg        <= '0;
            count_reg     <= '0;
            res1_reg      <= '0;
            res2_reg      <= '0;
            hold_word_reg <= '0;
            hold_full_reg <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            tp_reg        <= tp_next;
            count_reg     <= count_next;
            res1_reg      <= res1_next;
            res2_reg      <= res2_next;
            hold_word_reg <= hold_word_next;
            hold_full_reg <= hold_full_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An idle shifter never leaves a full buffer waiting.
    a_idle_shifter_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !hold_full_reg)
        else $error("idle shifter with full holding buffer");

    // Once a period is programmed, the tick period never returns to zero.
    a_period_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        tp_reg != '0 |=> tp_reg != '0)
        else $error("tick period fell back to zero");

    // No request is taken while the divider works.
    a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == utxbt_pkg::ST_DIV |-> !in_ready)
        else $error("request accepted during period division");

    // With a tick period above one, the residues stay below the period and below period-1.
    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        tp_gt1 |-> (res2_reg < tp_reg) && (res1_reg < tp_minus1))
        else $error("tick residue out of range");

endmodule

`default_nettype wire

/* hw/rtl/utxbt_div.sv */
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module utxbt_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [utxbt_pkg::TICKP_W-1:0]      dividend,
    input  wire logic [utxbt_pkg::LINE_W-1:0]       divisor,
    output logic                                    done,
    output logic [utxbt_pkg::TICKP_W-1:0]           quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [utxbt_pkg::STEP_W-1:0]       step_reg;
    logic [utxbt_pkg::TICKP_W-1:0]      quo_reg;
    logic [utxbt_pkg::LINE_W-1:0]       rem_reg;
    logic [utxbt_pkg::LINE_W-1:0]       div_reg;

    logic [utxbt_pkg::LINE_W:0]         trial;
    logic [utxbt_pkg::LINE_W:0]         diff;
    logic                               fits;

    assign trial = {rem_reg, quo_reg[utxbt_pkg::TICKP_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= utxbt_pkg::STEP_W'(utxbt_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[utxbt_pkg::TICKP_W-2:0], fits};
            rem_reg <= fits ? diff[utxbt_pkg::LINE_W-1:0] : trial[utxbt_pkg::LINE_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* bench/utxbt_checker.sv */
`timescale 1ns / 100ps

// Watches the request and result channels and the register port of the UART transmit
// block, predicts each result from its own copy of the transmit state, and
// compares every accepted result against the oldest prediction.
module utxbt_checker
    import utxbt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire in_t         in_data,

    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire out_t        out_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,

    output int unsigned      mismatches,
    output int unsigned      outstanding
);

    localparam logic [2:0] ADDR_LINE_LENGTH = {CFG_LINE_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_CYCLE_EXACT = {CFG_CYCLE_EXACT, 2'b00};

    // Register copies.
    logic [LINE_W-1:0]  line_len_cfg;
    logic               exact_cfg;

    // Transmit state.
    logic [WORD_W-1:0]  period_q;
    logic [TICKP_W-1:0] tick_period_q;
    logic [COUNT_W-1:0] tick_count_q;
    logic [WORD_W-1:0]  hold_word_q;
    logic               hold_full_q;
    logic               shifter_busy_q;
    logic [WORD_W-1:0]  shifter_word_q;
    logic               loaded_now;

    out_t               expected_results[$];
    int unsigned        fail_count;

    // Moves a full holding buffer into an idle shifter.
    function automatic void move_to_shifter();
        if (!shifter_busy_q && hold_full_q) begin
            shifter_word_q = hold_word_q;
            hold_full_q    = 1'b0;
            loaded_now     = 1'b1;
            shifter_busy_q = (tick_period_q > 19'd1);
        end
    endfunction

    function automatic void finish_shift();
        if (shifter_busy_q) begin
            shifter_busy_q = 1'b0;
            move_to_shifter();
        end
    endfunction

    function automatic out_t predict_tx_result(input in_t req);
        out_t        res;
        logic [31:0] divisor;
        logic [31:0] quotient;
        res        = '0;
        loaded_now = 1'b0;
        case (req.action)
            ACT_PERIOD: begin
                if (req.write_data != period_q) begin
                    divisor  = (line_len_cfg == '0) ? 32'd1 : 32'(line_len_cfg);
                    quotient = ((32'(req.write_data & PERIOD_LOW_MASK) + 32'd1)
                               * (req.write_data[NINE_BIT_POS] ? 32'd10 : 32'd9))
                               / divisor;
                    if (quotient == 32'd0)
                        quotient = 32'd1;
                    period_q      = req.write_data;
                    tick_period_q = quotient[TICKP_W-1:0];
                    tick_count_q  = '0;
                end
            end
            ACT_DATA: begin
                move_to_shifter();
                hold_word_q = req.write_data;
                if (req.write_data != '0) begin
                    hold_full_q = 1'b1;
                    move_to_shifter();
                end
            end
            ACT_STATUS: begin
                res.read_data = STAT_FIXED;
                if (!hold_full_q)
                    res.read_data |= STAT_TBE;
                if (!shifter_busy_q)
                    res.read_data |= STAT_TSRE;
            end
            ACT_TICK: begin
                if (tick_period_q != '0) begin
                    tick_count_q = tick_count_q + 32'd1;
                    if (tick_period_q == 19'd1
                        || (tick_count_q % (tick_period_q - 19'd1)) == 0)
                        finish_shift();
                    else if ((tick_count_q % tick_period_q) == 0 && !exact_cfg)
                        finish_shift();
                end
            end
        endcase
        res.tbe_irq    = loaded_now;
        res.load_valid = loaded_now;
        res.shift_word = loaded_now ? shifter_word_q : '0;
        return res;
    endfunction

    function automatic int unsigned field_differs(input string name,
                                                  input logic [WORD_W-1:0] want,
                                                  input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_t want;
        if (!rst_n) begin
            line_len_cfg   = LINE_LENGTH_RESET;
            exact_cfg      = 1'b0;
            period_q       = '0;
            tick_period_q  = '0;
            tick_count_q   = '0;
            hold_word_q    = '0;
            hold_full_q    = 1'b0;
            shifter_busy_q = 1'b0;
            shifter_word_q = '0;
            expected_results.delete();
            fail_count     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_LINE_LENGTH)
                    line_len_cfg = pwdata[LINE_W-1:0];
                else if (paddr == ADDR_CYCLE_EXACT)
                    exact_cfg = pwdata[0];
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result %h arrived with no request waiting",
                             $time, out_data);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    fail_count += field_differs("read_data", want.read_data,
                                                out_data.read_data);
                    fail_count += field_differs("tbe_irq", 16'(want.tbe_irq),
                                                16'(out_data.tbe_irq));
                    fail_count += field_differs("load_valid", 16'(want.load_valid),
                                                16'(out_data.load_valid));
                    fail_count += field_differs("shift_word", want.shift_word,
                                                out_data.shift_word);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_tx_result(in_data));
        end
        mismatches  <= fail_count;
        outstanding <= expected_results.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

// Top of the UART transmit bench. This module only creates stimulus: a
// short directed sequence, then several phases of random requests, each
// phase under its own line length and cycle-exact setting. The checker
// beside the block predicts and compares every result and reports its
// failure count back here for the verdict.
module tb;
    import utxbt_pkg::*;

    localparam logic [2:0] ADDR_LINE_LENGTH = {CFG_LINE_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_CYCLE_EXACT = {CFG_CYCLE_EXACT, 2'b00};

    localparam int PHASES           = 6;
    localparam int REQUESTS_PER_PHASE = 190;
    localparam int MAX_GAP          = 14;
    // A period change runs the divider; the settle time covers it.
    localparam int SETTLE_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT   = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    in_t         request_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_t        result_data;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatches;
    int unsigned outstanding;

    // Stimulus shaping state: whether gaps and stalls are drawn right now,
    // the line length in force (to keep tick periods short enough for ticks
    // to matter) and the period most recently written (to repeat it).
    bit          sender_gaps_on = 1'b0;
    bit          receiver_stalls_on = 1'b0;
    int unsigned line_len_now = LINE_LENGTH_RESET;
    logic [15:0] last_period = '0;
    int unsigned quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    uart_tx_buffer_timing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (request_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (result_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    utxbt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (request_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (result_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Offers one request and returns at the edge where it is accepted.
    // Valid is left high on return, so a request that follows with no gap
    // keeps it high; a gap lowers it first. The caller lowers it once the
    // last request of a run of requests has gone.
    task automatic send_request(input action_t act, input logic [15:0] value);
        int unsigned gap;
        gap = sender_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (act == ACT_PERIOD)
            last_period = value;
        in_valid                <= 1'b1;
        request_data.action     <= act;
        request_data.write_data <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    // The first edge is always taken, so a request accepted at the current
    // edge is already counted before the count is looked at.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Writes both registers back to back; psel stays high between the two
    // transfers and each access phase completes on pready.
    task automatic apply_settings(input int unsigned len, input bit exact);
        logic [2:0]  addrs[2];
        logic [31:0] values[2];
        addrs[0]  = ADDR_LINE_LENGTH;
        addrs[1]  = ADDR_CYCLE_EXACT;
        values[0] = 32'(len);
        values[1] = 32'(exact);
        for (int r = 0; r < 2; r++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= addrs[r];
            pwdata  <= values[r];
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        line_len_now = len;
    endtask

    // Random request mix. Ticks dominate so that the shifter actually
    // finishes; period writes mostly pick a low field near the line length,
    // which keeps the tick period short, and sometimes repeat the stored
    // value or take any 16-bit value at all.
    task automatic send_random_request();
        int unsigned pick;
        int unsigned span;
        int unsigned low;
        logic [15:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            if (pick < 3)
            begin
                value = last_period;
            end
            else if (pick < 5)
            begin
                value = 16'($urandom);
            end
            else
            begin
                span  = (line_len_now == 0) ? 1 : line_len_now;
                low   = $urandom_range(0, 2 * span + 8);
                value = {1'($urandom), low[14:0]};
            end
            send_request(ACT_PERIOD, value);
        end
        else if (pick < 40)
        begin
            value = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
            send_request(ACT_DATA, value);
        end
        else if (pick < 55)
        begin
            send_request(ACT_STATUS, 16'($urandom));
        end
        else
        begin
            send_request(ACT_TICK, 16'($urandom));
        end
    endtask

    // Receiver: before each result it may hold ready low for a drawn number
    // of cycles, then waits with ready high until a result is taken. Every
    // few dozen results it decides whether to stall at all, so that there
    // are stretches of back-to-back results too.
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
                receiver_stalls_on = ($urandom_range(0, 3) != 0);
            stall = receiver_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // Watchdog: any accepted request, result or register write counts as
    // progress. A long stretch with none of them ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int unsigned phase_len[PHASES];
        bit          phase_exact[PHASES];

        // Line length extremes (including zero, which divides as one) and
        // both cycle-exact modes; the fifth phase is drawn at random.
        phase_len   = '{1, 511, 0, 227, 0, 5};
        phase_exact = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        phase_len[4]   = $urandom_range(1, 511);
        phase_exact[4] = 1'($urandom);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset line length of 227.
        // Status before anything happened, then a tick while ticks are
        // still ignored because no period has been set.
        send_request(ACT_STATUS, 16'h0000);
        send_request(ACT_TICK,   16'h0000);
        // A zero data write is dropped; all-ones loads and, with no period
        // yet, the shifter empties at once.
        send_request(ACT_DATA,   16'h0000);
        send_request(ACT_DATA,   16'hffff);
        send_request(ACT_STATUS, 16'h0000);
        // Period zero matches the stored reset value, so neither of these
        // writes changes anything.
        send_request(ACT_PERIOD, 16'h0000);
        send_request(ACT_PERIOD, 16'h0000);
        send_request(ACT_DATA,   16'h8001);
        send_request(ACT_TICK,   16'h0000);
        // All-ones period: nine-bit mode and the largest low field.
        send_request(ACT_PERIOD, 16'hffff);
        // Low field 100 gives a tick period of four.
        send_request(ACT_PERIOD, 16'h0064);
        // One word goes into the shifter, a second fills the buffer and the third,
        // a zero, overwrites it while the full mark stays.
        send_request(ACT_DATA,   16'h1234);
        send_request(ACT_DATA,   16'h5678);
        send_request(ACT_DATA,   16'h0000);
        send_request(ACT_STATUS, 16'h0000);
        // The third tick hits a multiple of period-1 and loads the zero
        // word; the fourth hits a multiple of the period itself.
        send_request(ACT_TICK,   16'h0000);
        send_request(ACT_TICK,   16'h0000);
        send_request(ACT_TICK,   16'h0000);
        send_request(ACT_TICK,   16'h0000);
        send_request(ACT_DATA,   16'h00ff);
        send_request(ACT_TICK,   16'h0000);
        send_request(ACT_TICK,   16'h0000);
        send_request(ACT_STATUS, 16'h0000);
        send_request(ACT_PERIOD, 16'h8064);
        hold_until_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Registers change only here, with no request in flight.
            apply_settings(phase_len[phase], phase_exact[phase]);
            for (int n = 0; n < REQUESTS_PER_PHASE; n++)
            begin
                if (n % 32 == 0)
                    sender_gaps_on = ($urandom_range(0, 3) != 0);
                // Once, halfway through a phase, let the block run dry
                // before offering the next request.
                if (phase == 1 && n == REQUESTS_PER_PHASE / 2)
                    hold_until_drained();
                send_random_request();
            end
            hold_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
